[src/scpa_pkg.sv]
package scpa_pkg;

    // pool geometry
    localparam int NUM_CLASSES      = 5;
    localparam int BLOCKS_PER_CLASS = 64;
    localparam int POOL_ENTRIES     = NUM_CLASSES * BLOCKS_PER_CLASS;

    // field widths fixed by the interface
    localparam int SIZE_W  = 16;
    localparam int CLASS_W = 3;
    localparam int IDX_W   = 6;

    // link holds 0 .. BLOCKS_PER_CLASS, the top value marks end of list
    localparam int LINK_W  = $clog2(BLOCKS_PER_CLASS + 1);
    localparam int ADDR_W  = $clog2(POOL_ENTRIES);
    localparam int WORD_W  = LINK_W + 1;

    localparam logic [SIZE_W-1:0] CLASS_LIMIT [NUM_CLASSES] = '{
        16'd64, 16'd128, 16'd256, 16'd512, 16'd1024
    };

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_GRANTED   = 3'd0,
        STAT_OVERSIZE  = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_FREED     = 3'd3,
        STAT_FREE_ERR  = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic               action;
        logic [SIZE_W-1:0]  request_size;
        logic [CLASS_W-1:0] free_class;
        logic [IDX_W-1:0]   free_index;
    } in_word_t;

    typedef struct packed {
        status_t            status;
        logic [CLASS_W-1:0] block_class;
        logic [IDX_W-1:0]   block_index;
    } out_word_t;

    // size class lookup result
    typedef struct packed {
        logic               oversize;
        logic [CLASS_W-1:0] cls;
    } class_dec_t;

endpackage

[src/scpa_pool_ram.sv]
module scpa_pool_ram #(
    parameter int DEPTH  = 320,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 9
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/scpa_size_decode.sv]
module scpa_size_decode (
    input  logic [scpa_pkg::SIZE_W-1:0] request_size,
    output scpa_pkg::class_dec_t         dec
);
    import scpa_pkg::*;

    // smallest class whose limit covers the size
    always_comb begin
        dec.oversize = request_size > CLASS_LIMIT[NUM_CLASSES-1];
        dec.cls      = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (request_size <= CLASS_LIMIT[c]) begin
                dec.cls = CLASS_W'(c);
            end
        end
    end

endmodule

[src/size_class_pool_allocator.sv]
// Segregated free-list pool allocator with five size classes (64, 128, 256,
// 512 and 1024 bytes), each a pool of 64 blocks kept on a LIFO free list. An
// allocate word maps its byte count to the smallest fitting class and pops
// that list's head, returning class and block index; a size above 1024 or an
// empty class yields a fallback status instead. A free word names a class and
// index; an allocated block is pushed back on its list head, anything else
// reports a free error. The pool memory entry (next link and in-use flag)
// is read at acceptance; the result is loaded in the execute state once the
// output register is free, while the entry is modified and written back,
// and the next word is only taken in the cycle after that write. The result
// sits in an output register, so a new word is accepted while the previous
// result still waits on m_ready; a stalled m_ready holds the block in its
// execute state. No clearing pass is needed after reset: a per-class fill count
// marks how far each pool has ever been handed out, and entries at or beyond
// it read as their reset contents (link to the next index, not in use).
module size_class_pool_allocator (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  scpa_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output scpa_pkg::out_word_t  m_data
);
    import scpa_pkg::*;

    // control state
    state_t state_reg, state_next;
    logic   m_valid_reg;
    out_word_t m_data_reg;

    // per-class list heads and fill counts
    logic [LINK_W-1:0] head_reg [NUM_CLASSES];
    logic [LINK_W-1:0] fill_reg [NUM_CLASSES];

    // latched request
    logic               req_action_reg;
    logic               req_bad_reg;      // oversize, or free of bad class/index
    logic [CLASS_W-1:0] req_cls_reg;
    logic [IDX_W-1:0]   req_idx_reg;
    logic [LINK_W-1:0]  req_head_reg;
    logic [LINK_W-1:0]  req_fill_reg;
    logic [ADDR_W-1:0]  req_slot_reg;

    // issue side
    class_dec_t         dec;
    logic               accept;
    logic               cls_ok;
    logic               idx_ok;
    logic [CLASS_W-1:0] sel_cls;
    logic [CLASS_W-1:0] look_cls;
    logic [LINK_W-1:0]  head_pick;
    logic [ADDR_W-1:0]  slot_next;

    // execute side
    logic               out_free;
    logic               done;
    logic [WORD_W-1:0]  ram_rdata;
    logic               ram_we;
    logic [WORD_W-1:0]  ram_wdata;
    logic               mem_used;
    logic [LINK_W-1:0]  mem_link;
    logic               fresh;
    logic               blk_used;
    logic               head_we;
    logic [LINK_W-1:0]  head_wdata;
    logic               fill_we;
    out_word_t          result;

    scpa_size_decode u_dec (
        .request_size (s_data.request_size),
        .dec          (dec)
    );

    scpa_pool_ram #(
        .DEPTH  (POOL_ENTRIES),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (req_slot_reg),
        .wdata  (ram_wdata),
        .re     (accept),
        .raddr  (slot_next),
        .rdata  (ram_rdata)
    );

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign done     = (state_reg == ST_EXEC) && out_free;

    // ---------------- issue: pick class, look up head, start memory read
    always_comb begin
        sel_cls   = (s_data.action == ACT_ALLOC) ? dec.cls : s_data.free_class;
        idx_ok    = LINK_W'(s_data.free_index) < LINK_W'(BLOCKS_PER_CLASS);
        cls_ok    = (s_data.action == ACT_ALLOC) ? !dec.oversize
                  : (s_data.free_class < CLASS_W'(NUM_CLASSES));
        look_cls  = cls_ok ? sel_cls : '0;
        head_pick = head_reg[look_cls];
        if (s_data.action == ACT_ALLOC) begin
            slot_next = ADDR_W'(look_cls) * ADDR_W'(BLOCKS_PER_CLASS)
                      + ADDR_W'(head_pick);
        end else begin
            slot_next = ADDR_W'(look_cls) * ADDR_W'(BLOCKS_PER_CLASS)
                      + ADDR_W'(s_data.free_index);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_action_reg <= s_data.action;
            req_bad_reg    <= !cls_ok || ((s_data.action == ACT_FREE) && !idx_ok);
            req_cls_reg    <= sel_cls;
            req_idx_reg    <= s_data.free_index;
            req_head_reg   <= head_pick;
            req_fill_reg   <= fill_reg[look_cls];
            req_slot_reg   <= slot_next;
        end
    end

    // ---------------- execute: resolve memory word, update lists
    assign mem_link = ram_rdata[LINK_W-1:0];
    assign mem_used = ram_rdata[LINK_W];

    // entries at or past the fill count were never handed out: reset contents
    assign fresh    = req_head_reg >= req_fill_reg;
    assign blk_used = (LINK_W'(req_idx_reg) < req_fill_reg) && mem_used;

    always_comb begin
        result      = '{status: STAT_GRANTED, block_class: '0, block_index: '0};
        ram_we      = 1'b0;
        ram_wdata   = '0;
        head_we     = 1'b0;
        head_wdata  = '0;
        fill_we     = 1'b0;
        if (req_action_reg == ACT_ALLOC) begin
            if (req_bad_reg) begin
                result.status = STAT_OVERSIZE;
            end else if (req_head_reg >= LINK_W'(BLOCKS_PER_CLASS)) begin
                result.status      = STAT_EMPTY;
                result.block_class = req_cls_reg;
            end else begin
                // pop the head, mark it in use
                result.status      = STAT_GRANTED;
                result.block_class = req_cls_reg;
                result.block_index = req_head_reg[IDX_W-1:0];
                ram_we             = done;
                ram_wdata          = {1'b1, mem_link};
                head_we            = done;
                head_wdata         = fresh ? LINK_W'(req_head_reg + LINK_W'(1)) : mem_link;
                fill_we            = done && fresh;
            end
        end else begin
            result.block_class = req_cls_reg;
            result.block_index = req_idx_reg;
            if (req_bad_reg || !blk_used) begin
                result.status = STAT_FREE_ERR;
            end else begin
                // push back on the head
                result.status = STAT_FREED;
                ram_we        = done;
                ram_wdata     = {1'b0, req_head_reg};
                head_we       = done;
                head_wdata    = LINK_W'(req_idx_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
        end else begin
            if (head_we) begin
                head_reg[req_cls_reg] <= head_wdata;
            end
            if (fill_we) begin
                fill_reg[req_cls_reg] <= LINK_W'(req_head_reg + LINK_W'(1));
            end
        end
    end

    // ---------------- sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: s_ready = 1'b0;
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[src/scpa_checker.sv]
module scpa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input scpa_pkg::out_word_t m_data
);
    import scpa_pkg::*;

    // result register comes up empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    // one word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous word busy");

    // oversize fallback carries no block
    a_oversize_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_OVERSIZE)
            |-> (m_data.block_class == '0) && (m_data.block_index == '0))
        else $error("oversize result names a block");

    // granted or freed blocks belong to a real class
    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_data.status == STAT_GRANTED) || (m_data.status == STAT_FREED))
            |-> (m_data.block_class < CLASS_W'(NUM_CLASSES)))
        else $error("block result with invalid class");

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (.*);
